// ===== src/rf_ambient_bin_baseline_filter_assert.svh =====
// Assertion macros shared by the ambient-bin baseline filter RTL.
`ifndef RF_AMBIENT_BIN_BASELINE_FILTER_ASSERT_SVH
`define RF_AMBIENT_BIN_BASELINE_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RFAB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("rfab assertion failed");
`define RFAB_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("rfab assertion failed");
`else
`define RFAB_ASSERT_IMP(label, clk, rst_n, a, c)
`define RFAB_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== src/rfab_pkg.sv =====
// Types and constants of the ambient-bin baseline filter.
package rfab_pkg;

    typedef struct packed {
        logic signed [8:0] level;
        logic [8:0]        bin;
        logic              sweep_end;
    } sample_t;

    typedef struct packed {
        logic [8:0] bin_out;
        logic       ambient;
        logic       ready_res;
    } result_t;

    localparam logic [3:0] ADDR_MARGIN = 4'h0;
    localparam logic [3:0] ADDR_VARLIM = 4'h4;
    localparam logic [3:0] ADDR_UNLOCK = 4'h8;

    localparam logic [7:0]  MARGIN_RST = 8'd20;
    localparam logic [15:0] VARLIM_RST = 16'd36;
    localparam logic [7:0]  UNLOCK_RST = 8'd20;

    localparam logic signed [9:0] NO_FLOOR = -10'sd255;

endpackage

// ===== src/rf_ambient_bin_baseline_filter.sv =====
// Ambient-bin baseline filter: per-bin sweep history, one-time snapshot, lock tracking.
//
//  channel   direction  handshake                 payload
//  sample    in         sample_valid/sample_stall  sample_t (level, bin, sweep_end)
//  result    out        result_valid/result_stall  result_t (bin_out, ambient, ready_res)
//  config    in         APB psel/penable/pready    margin, variance limit, unlock drop
//
// A sample is handled in order: a history write with lock and baseline reads, then the check.
// After reset a clearing pass zeroes the history.
// The snapshot at a sweep end walks the history serially, limited by the single history
// read port and the shared compare and multiply.
// A stalled result holds off the next sample until the result is taken.
`include "rf_ambient_bin_baseline_filter_assert.svh"
module rf_ambient_bin_baseline_filter
    import rfab_pkg::*;
#(
    parameter int BIN_COUNT        = 512,
    parameter int HISTORY_DEPTH    = 8,
    parameter int CANDIDATE_STRIDE = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TOTAL = BIN_COUNT * HISTORY_DEPTH;
    localparam int AW    = $clog2(TOTAL);
    localparam int BW    = $clog2(BIN_COUNT);
    localparam int SLW   = $clog2(HISTORY_DEPTH);
    localparam int DL    = $clog2(HISTORY_DEPTH);
    localparam int WW    = $clog2(HISTORY_DEPTH + 1);
    localparam int CNW   = $clog2(BIN_COUNT + 1);
    localparam int CIW   = $clog2(BIN_COUNT + CANDIDATE_STRIDE + 1);
    localparam int CAW   = $clog2((BIN_COUNT + CANDIDATE_STRIDE) * HISTORY_DEPTH + 1);
    localparam int SW    = 9 + DL;
    localparam int QW    = 18 + DL;
    localparam int CW    = 19 + 2 * DL;
    localparam int UW    = 11 + DL;

    localparam logic [10:0]           BIN_LIMIT = 11'(BIN_COUNT);
    localparam logic [CNW:0]          HALF      = (CNW + 1)'(BIN_COUNT / 2);
    localparam logic signed [CW-1:0]  CDEP      = CW'(HISTORY_DEPTH);
    localparam logic signed [UW-1:0]  UDEP      = UW'(HISTORY_DEPTH);

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_CHECK   = 14'b00000000000100,
        S_FCRD    = 14'b00000000001000,
        S_FCLAT   = 14'b00000000010000,
        S_SCAN    = 14'b00000000100000,
        S_SCDRAIN = 14'b00000001000000,
        S_FDEC    = 14'b00000010000000,
        S_WRUN    = 14'b00000100000000,
        S_WDRAIN  = 14'b00001000000000,
        S_WE1     = 14'b00010000000000,
        S_WE2     = 14'b00100000000000,
        S_RR      = 14'b01000000000000,
        S_RRL     = 14'b10000000000000
    } state_t;

    state_t state_reg;

    logic [7:0]  margin_reg;
    logic [15:0] varlim_reg;
    logic [7:0]  unlock_reg;

    logic signed [8:0] hist_mem [TOTAL];
    logic              lock_mem [BIN_COUNT];
    logic signed [SW-1:0] base_mem [BIN_COUNT];

    logic signed [8:0]    hist_rdata_reg;
    logic                 lock_rdata_reg;
    logic signed [SW-1:0] base_rdata_reg;

    logic              hist_we, lock_we, lock_wdata, base_we;
    logic [AW-1:0]     hist_waddr, hist_raddr;
    logic signed [8:0] hist_wdata;
    logic [BW-1:0]     lock_waddr, lock_raddr, base_raddr;

    logic              result_valid_reg;
    result_t           result_reg;
    logic              snap_done_reg;
    logic [SLW-1:0]    slot_reg, snap_slot_reg, k_reg;
    logic [WW-1:0]     warm_reg;

    logic signed [8:0] item_level_reg;
    logic [8:0]        item_bin_reg;
    logic              item_last_reg, item_ok_reg;

    logic [AW-1:0]     walk_addr_reg;
    logic [BW-1:0]     walk_bin_reg, scan_j_reg;
    logic [CAW-1:0]    cand_addr_reg, scan_addr_reg;
    logic [CIW-1:0]    cand_idx_reg;
    logic signed [8:0] cand_reg;
    logic [CNW-1:0]    below_reg, equal_reg;
    logic              rdv_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [QW-1:0] sq_reg;
    logic signed [CW-1:0] prod_reg;
    logic signed [9:0]    gate_reg;

    logic              accept, in_ok, unlock_hit, lock_hit, median_hit, snap_start;
    logic [BW-1:0]     in_bin_idx;
    logic [AW-1:0]     sample_addr;
    logic [CIW-1:0]    cand_idx_next;
    logic signed [CW-1:0] var_lhs, var_rhs;

    assign pready       = 1'b1;
    assign sample_stall = (state_reg != S_IDLE) || (result_valid_reg && result_stall);
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign in_ok       = {2'b00, sample.bin} < BIN_LIMIT;
    assign in_bin_idx  = BW'(sample.bin);
    assign sample_addr = AW'(in_bin_idx) * AW'(HISTORY_DEPTH) + AW'(slot_reg);

    assign unlock_hit = snap_done_reg && item_ok_reg && lock_rdata_reg &&
        (UDEP * UW'(item_level_reg) <
         UW'(base_rdata_reg) - UDEP * UW'($signed({1'b0, unlock_reg})));

    assign var_lhs  = CDEP * CW'(sq_reg) - prod_reg;
    assign var_rhs  = CW'($signed({1'b0, varlim_reg})) * CDEP * CDEP;
    assign lock_hit = (var_lhs < var_rhs) && (UW'(sum_reg) > UDEP * UW'(gate_reg));

    assign median_hit    = ((CNW + 1)'(below_reg) <= HALF) &&
                           ((CNW + 1)'(below_reg) + (CNW + 1)'(equal_reg) > HALF);
    assign cand_idx_next = cand_idx_reg + CIW'(CANDIDATE_STRIDE);

    assign snap_start = item_last_reg && !snap_done_reg && (warm_reg >= WW'(HISTORY_DEPTH));

    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = walk_addr_reg;
        hist_wdata = '0;
        hist_raddr = walk_addr_reg;
        lock_we    = 1'b0;
        lock_waddr = walk_bin_reg;
        lock_wdata = 1'b0;
        lock_raddr = BW'(item_bin_reg);
        base_we    = 1'b0;
        base_raddr = in_bin_idx;
        unique case (state_reg)
            S_CLEAR:
            begin
                hist_we = 1'b1;
                lock_we = (k_reg == '0);
            end
            S_IDLE:
            begin
                hist_we    = accept && in_ok;
                hist_waddr = sample_addr;
                hist_wdata = sample.level;
                lock_raddr = in_bin_idx;
            end
            S_CHECK:
            begin
                lock_we    = unlock_hit;
                lock_waddr = BW'(item_bin_reg);
            end
            S_FCRD: hist_raddr = cand_addr_reg[AW-1:0];
            S_SCAN: hist_raddr = scan_addr_reg[AW-1:0];
            S_WE2:
            begin
                lock_we    = lock_hit;
                lock_wdata = 1'b1;
                base_we    = lock_hit;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lock_we)
        begin
            lock_mem[lock_waddr] <= lock_wdata;
        end
        lock_rdata_reg <= lock_mem[lock_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (base_we)
        begin
            base_mem[walk_bin_reg] <= sum_reg;
        end
        base_rdata_reg <= base_mem[base_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RST;
            varlim_reg <= VARLIM_RST;
            unlock_reg <= UNLOCK_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr)
                ADDR_MARGIN: margin_reg <= pwdata[7:0];
                ADDR_VARLIM: varlim_reg <= pwdata[15:0];
                ADDR_UNLOCK: unlock_reg <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_MARGIN: prdata = {24'd0, margin_reg};
            ADDR_VARLIM: prdata = {16'd0, varlim_reg};
            ADDR_UNLOCK: prdata = {24'd0, unlock_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_level_reg <= sample.level;
            item_bin_reg   <= sample.bin;
            item_last_reg  <= sample.sweep_end;
            item_ok_reg    <= in_ok;
        end
        if (rdv_reg && (state_reg == S_SCAN || state_reg == S_SCDRAIN))
        begin
            if (hist_rdata_reg < cand_reg)
            begin
                below_reg <= below_reg + 1'b1;
            end
            else if (hist_rdata_reg == cand_reg)
            begin
                equal_reg <= equal_reg + 1'b1;
            end
        end
        if (rdv_reg && (state_reg == S_WRUN || state_reg == S_WDRAIN))
        begin
            sum_reg <= sum_reg + SW'(hist_rdata_reg);
            sq_reg  <= sq_reg + QW'(hist_rdata_reg * hist_rdata_reg);
        end
        if (state_reg == S_FCLAT)
        begin
            cand_reg  <= hist_rdata_reg;
            below_reg <= '0;
            equal_reg <= '0;
        end
        if (state_reg == S_WE1)
        begin
            prod_reg <= CW'(sum_reg) * CW'(sum_reg);
        end
        if (state_reg == S_FDEC)
        begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            gate_reg <= (median_hit ? 10'(cand_reg) : NO_FLOOR) + $signed({2'b00, margin_reg});
        end
        if (state_reg == S_WE2)
        begin
            sum_reg <= '0;
            sq_reg  <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            snap_done_reg    <= 1'b0;
            slot_reg         <= '0;
            snap_slot_reg    <= '0;
            warm_reg         <= '0;
            walk_addr_reg    <= '0;
            walk_bin_reg     <= '0;
            k_reg            <= '0;
            scan_j_reg       <= '0;
            scan_addr_reg    <= '0;
            cand_addr_reg    <= '0;
            cand_idx_reg     <= '0;
            rdv_reg          <= 1'b0;
        end
        else
        begin
            rdv_reg <= (state_reg == S_SCAN) || (state_reg == S_WRUN);
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    walk_addr_reg <= walk_addr_reg + 1'b1;
                    if (k_reg == SLW'(HISTORY_DEPTH - 1))
                    begin
                        k_reg        <= '0;
                        walk_bin_reg <= walk_bin_reg + 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if (walk_addr_reg == AW'(TOTAL - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    result_reg.bin_out   <= item_bin_reg;
                    result_reg.ambient   <= item_ok_reg && lock_rdata_reg && !unlock_hit;
                    result_reg.ready_res <= snap_done_reg;
                    if (item_last_reg)
                    begin
                        slot_reg <= (slot_reg == SLW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                    end
                    if (item_last_reg && !snap_done_reg && (warm_reg < WW'(HISTORY_DEPTH)))
                    begin
                        warm_reg <= warm_reg + 1'b1;
                    end
                    if (snap_start)
                    begin
                        snap_slot_reg <= slot_reg;
                        cand_addr_reg <= CAW'(slot_reg);
                        cand_idx_reg  <= '0;
                        state_reg     <= S_FCRD;
                    end
                    else
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                S_FCRD: state_reg <= S_FCLAT;
                S_FCLAT:
                begin
                    scan_addr_reg <= CAW'(snap_slot_reg);
                    scan_j_reg    <= '0;
                    state_reg     <= S_SCAN;
                end
                S_SCAN:
                begin
                    scan_addr_reg <= scan_addr_reg + CAW'(HISTORY_DEPTH);
                    scan_j_reg    <= scan_j_reg + 1'b1;
                    if (scan_j_reg == BW'(BIN_COUNT - 1))
                    begin
                        state_reg <= S_SCDRAIN;
                    end
                end
                S_SCDRAIN: state_reg <= S_FDEC;
                S_FDEC:
                begin
                    walk_addr_reg <= '0;
                    walk_bin_reg  <= '0;
                    k_reg         <= '0;
                    if (median_hit || (cand_idx_next >= CIW'(BIN_COUNT)))
                    begin
                        state_reg <= S_WRUN;
                    end
                    else
                    begin
                        cand_idx_reg  <= cand_idx_next;
                        cand_addr_reg <= cand_addr_reg +
                                         CAW'(CANDIDATE_STRIDE * HISTORY_DEPTH);
                        state_reg     <= S_FCRD;
                    end
                end
                S_WRUN:
                begin
                    walk_addr_reg <= walk_addr_reg + 1'b1;
                    k_reg         <= k_reg + 1'b1;
                    if (k_reg == SLW'(HISTORY_DEPTH - 1))
                    begin
                        state_reg <= S_WDRAIN;
                    end
                end
                S_WDRAIN: state_reg <= S_WE1;
                S_WE1:    state_reg <= S_WE2;
                S_WE2:
                begin
                    k_reg <= '0;
                    if (walk_bin_reg == BW'(BIN_COUNT - 1))
                    begin
                        snap_done_reg <= 1'b1;
                        state_reg     <= S_RR;
                    end
                    else
                    begin
                        walk_bin_reg <= walk_bin_reg + 1'b1;
                        state_reg    <= S_WRUN;
                    end
                end
                S_RR: state_reg <= S_RRL;
                S_RRL:
                begin
                    state_reg            <= S_IDLE;
                    result_valid_reg     <= 1'b1;
                    result_reg.bin_out   <= item_bin_reg;
                    result_reg.ambient   <= item_ok_reg && lock_rdata_reg;
                    result_reg.ready_res <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `RFAB_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, accept, state_reg == S_CHECK)
    `RFAB_ASSERT_IMP(a_result_free_on_check, clk, rst_n, state_reg == S_CHECK, !result_valid_reg)
    `RFAB_ASSERT_IMP(a_ambient_needs_snapshot, clk, rst_n, result_valid && result.ambient, result.ready_res)

endmodule

// ===== tb/sv/ambient_scoreboard.sv =====
// Scoreboard class that predicts and checks the ambient-bin baseline filter results.
`timescale 1ns / 100ps
class ambient_scoreboard;
    int level_ring[512][8];
    int locked_sum[512];
    bit is_locked[512];
    bit snapshot_taken;
    int slot_ptr;
    int sweeps_seen;
    int margin = 20;
    int var_limit = 36;
    int drop = 20;
    rfab_pkg::result_t expected_results[$];
    int fails;

    function int floor_level(int slot);
        int cand;
        int below;
        int equal;
        for (int c = 0; c < 512; c += 7)
        begin
            cand = level_ring[c][slot];
            below = 0;
            equal = 0;
            for (int j = 0; j < 512; j++)
            begin
                if (level_ring[j][slot] < cand)
                    below++;
                else if (level_ring[j][slot] == cand)
                    equal++;
            end
            if (below <= 256 && below + equal > 256)
                return cand;
        end
        return -255;
    endfunction

    function void take_snapshot(int slot);
        longint gate;
        longint sum;
        longint sq;
        gate = floor_level(slot) + margin;
        for (int i = 0; i < 512; i++)
        begin
            sum = 0;
            sq = 0;
            for (int k = 0; k < 8; k++)
            begin
                sum += level_ring[i][k];
                sq += longint'(level_ring[i][k]) * level_ring[i][k];
            end
            if (8 * sq - sum * sum < longint'(var_limit) * 64 && sum > 8 * gate)
            begin
                is_locked[i] = 1;
                locked_sum[i] = int'(sum);
            end
        end
        snapshot_taken = 1;
    endfunction

    function void note_sample(rfab_pkg::sample_t s);
        int lvl;
        int b;
        int slot;
        rfab_pkg::result_t r;
        lvl = s.level;
        b = s.bin;
        slot = slot_ptr;
        level_ring[b][slot] = lvl;
        if (snapshot_taken && is_locked[b])
        begin
            if (longint'(8) * lvl < longint'(locked_sum[b]) - longint'(8) * drop)
                is_locked[b] = 0;
        end
        if (s.sweep_end)
        begin
            slot_ptr = (slot + 1) % 8;
            if (!snapshot_taken)
            begin
                if (sweeps_seen < 8)
                    sweeps_seen++;
                else
                    take_snapshot(slot);
            end
        end
        r.bin_out = s.bin;
        r.ambient = is_locked[b];
        r.ready_res = snapshot_taken;
        expected_results.push_back(r);
    endfunction

    function void check_result(rfab_pkg::result_t r);
        rfab_pkg::result_t e;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result transaction, bin_out %0d", r.bin_out);
            fails++;
            return;
        end
        e = expected_results.pop_front();
        if (r.bin_out !== e.bin_out)
        begin
            $error("bin_out expected %0d actual %0d", e.bin_out, r.bin_out);
            fails++;
        end
        if (r.ambient !== e.ambient)
        begin
            $error("ambient expected %0d actual %0d (bin %0d)", e.ambient, r.ambient, e.bin_out);
            fails++;
        end
        if (r.ready_res !== e.ready_res)
        begin
            $error("ready_res expected %0d actual %0d", e.ready_res, r.ready_res);
            fails++;
        end
    endfunction
endclass

// ===== tb/sv/testbench.sv =====
// Top-level testbench of the ambient-bin baseline filter.
`timescale 1ns / 100ps
module testbench
    import rfab_pkg::*;
();

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1850;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        sample_valid = 0;
    logic        sample_stall;
    sample_t     sample = '0;
    logic        result_valid;
    logic        result_stall = 0;
    result_t     result;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ambient_scoreboard sb;
    int cycles;
    int burst_left;
    int stall_left;
    int stall_mode;
    int sent;
    int base_level[512];
    int jitter[512];
    bit tracked[512];

    rf_ambient_bin_baseline_filter dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: result_stall = 0;
            1: result_stall = ($urandom_range(0, 3) == 0);
            2: result_stall = $urandom_range(0, 1);
            default: result_stall = ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    task automatic write_reg(input logic [3:0] addr, input int value);
        @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
        case (addr)
            ADDR_MARGIN: sb.margin = value & 8'hFF;
            ADDR_VARLIM: sb.var_limit = value & 16'hFFFF;
            default: sb.drop = value & 8'hFF;
        endcase
    endtask

    task automatic send(input int lvl, input int b, input bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                sample_valid = 0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        sample_valid = 1;
        sample.level = lvl[8:0];
        sample.bin = b[8:0];
        sample.sweep_end = last;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_sample(sample);
        burst_left--;
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        sample_valid = 0;
        while (sb.expected_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_sweep(input bit dips);
        int lvl;
        int last_bin;
        last_bin = 0;
        for (int b = 0; b < 512; b++)
            if (tracked[b])
                last_bin = b;
        for (int b = 0; b <= last_bin; b++)
        begin
            if ($urandom_range(0, 24) == 0)
                send($urandom_range(0, 511) - 256, $urandom_range(0, 511), 0);
            if (tracked[b] && (b == last_bin || $urandom_range(0, 9) != 0))
            begin
                lvl = base_level[b] + $urandom_range(0, 2 * jitter[b]) - jitter[b];
                if (dips && $urandom_range(0, 19) == 0)
                    lvl -= $urandom_range(0, 120);
                if (lvl < -256)
                    lvl = -256;
                if (lvl > 255)
                    lvl = 255;
                send(lvl, b, b == last_bin);
            end
        end
    endtask

    initial
    begin
        sb = new;
        for (int b = 0; b < 512; b++)
        begin
            tracked[b] = ($urandom_range(0, 9) == 0);
            base_level[b] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                                        : -$urandom_range(0, 256);
            jitter[b] = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(0, 15);
        end
        tracked[511] = 1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        write_reg(ADDR_MARGIN, 255);
        write_reg(ADDR_VARLIM, 0);
        write_reg(ADDR_UNLOCK, 255);
        send(-256, 0, 0);
        send(255, 1, 0);
        send(1, 2, 0);
        send(-1, 3, 0);
        send(-128, 100, 0);
        send(127, 300, 0);
        send(0, 511, 1);
        send(100, 5, 0);
        send(-255, 6, 0);
        send(170, 511, 1);
        drain();
        write_reg(ADDR_MARGIN, 0);
        write_reg(ADDR_VARLIM, 65535);
        write_reg(ADDR_UNLOCK, 0);
        drain();
        write_reg(ADDR_MARGIN, $urandom_range(0, 30));
        write_reg(ADDR_VARLIM, $urandom_range(16, 400));

        while (!sb.snapshot_taken)
            run_sweep(0);
        drain();

        while (sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 2))
                0: write_reg(ADDR_UNLOCK, 0);
                1: write_reg(ADDR_UNLOCK, 255);
                default: write_reg(ADDR_UNLOCK, $urandom_range(0, 60));
            endcase
            repeat ($urandom_range(1, 3)) run_sweep(1);
            drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.fails == 0 && sb.expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/rfab_pkg.sv
src/rf_ambient_bin_baseline_filter.sv
tb/sv/ambient_scoreboard.sv
tb/sv/testbench.sv
